@@ hw/rtl/rfe_pkg.sv @@
package rfe_pkg;

	localparam int ID_W       = 12;
	localparam int MEM_W      = 16;
	localparam int TOP_W      = 13;
	localparam int ERR_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TOP_CACHE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MEM_LIMIT = CFG_IDX_W'(1);

	localparam logic [ERR_W-1:0] ERR_NONE  = ERR_W'(0);
	localparam logic [ERR_W-1:0] ERR_EMPTY = ERR_W'(1);
	localparam logic [ERR_W-1:0] ERR_FULL  = ERR_W'(2);

	typedef enum logic [2:0] {
		RES_NONE,
		RES_IGNORED,
		RES_FULL,
		RES_ADD,
		RES_EMPTY,
		RES_EVICT
	} res_kind_t;

	typedef struct packed {
		logic      latch_item;
		logic      clr_wr;
		logic      add_commit;
		logic      pop;
		logic      cnt_rd_entry;
		logic      cnt_dec;
		logic      cnt_clr;
		logic      res_load;
		res_kind_t res;
	} cmd_t;

	typedef struct packed {
		logic is_evict;
		logic pinned;
		logic full;
		logic empty;
		logic below_limit;
		logic cnt_gt1;
		logic out_busy;
		logic clear_done;
	} sts_t;

endpackage

@@ hw/rtl/rfe_ram.sv @@
module rfe_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/rfe_datapath.sv @@
module rfe_datapath import rfe_pkg::*; #(
	parameter int NUM_BUCKETS = 4096,
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  opcode,
	input  logic [ID_W-1:0]       bucket,
	input  logic [MEM_W-1:0]      mem_in_use,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  ignored,
	output logic                  newly_tracked,
	output logic                  evicted_valid,
	output logic [ID_W-1:0]       evicted_bucket,
	output logic [ERR_W-1:0]      error_code,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int BW = $clog2(NUM_BUCKETS);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = FW;

	logic [TOP_W-1:0] top_cache_q;
	logic [MEM_W-1:0] mem_limit_q;
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [FW-1:0]    fill_q;
	logic [BW-1:0]    clr_idx_q;
	logic             out_valid_q;

	logic             opcode_q;
	logic [ID_W-1:0]  id_q;
	logic [MEM_W-1:0] mem_q;
	logic [ID_W-1:0]  entry_q;
	logic             fresh_q;
	logic             ignored_q;
	logic             fresh_out_q;
	logic             ev_valid_q;
	logic [ID_W-1:0]  ev_bucket_q;
	logic [ERR_W-1:0] err_q;

	logic [ID_W-1:0]  fifo_rdata;
	logic [CW-1:0]    cnt_rdata;
	logic             cnt_we;
	logic [BW-1:0]    cnt_waddr;
	logic [CW-1:0]    cnt_wdata;
	logic [BW-1:0]    cnt_raddr;
	logic             out_busy;

	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign out_busy = out_valid_q && out_stall;

	always_comb begin
		sts.is_evict    = opcode_q;
		sts.pinned      = ({1'b0, id_q} < top_cache_q) || (32'(id_q) >= 32'(NUM_BUCKETS));
		sts.full        = (fill_q == FW'(QUEUE_DEPTH));
		sts.empty       = (fill_q == '0);
		sts.below_limit = (mem_q < mem_limit_q);
		sts.cnt_gt1     = (cnt_rdata > CW'(1));
		sts.out_busy    = out_busy;
		sts.clear_done  = (clr_idx_q == BW'(NUM_BUCKETS - 1));
	end

	always_comb begin
		cnt_we    = cmd.clr_wr || cmd.add_commit || cmd.cnt_dec || cmd.cnt_clr;
		cnt_raddr = cmd.cnt_rd_entry ? BW'(fifo_rdata) : BW'(id_q);
		if (cmd.clr_wr) begin
			cnt_waddr = clr_idx_q;
		end else if (cmd.add_commit) begin
			cnt_waddr = BW'(id_q);
		end else begin
			cnt_waddr = BW'(entry_q);
		end
		if (cmd.add_commit) begin
			cnt_wdata = cnt_rdata + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_wdata = cnt_rdata - CW'(1);
		end else begin
			cnt_wdata = '0;
		end
	end

	rfe_ram #(
		.WIDTH (ID_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (cmd.add_commit),
		.waddr (tail_q),
		.wdata (id_q),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	rfe_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_BUCKETS)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_cache_q <= '0;
			mem_limit_q <= MEM_W'(4096);
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TOP_CACHE: top_cache_q <= cfg_data[TOP_W-1:0];
					REG_MEM_LIMIT: mem_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_wr) begin
				clr_idx_q <= clr_idx_q + BW'(1);
			end
			if (cmd.add_commit) begin
				tail_q <= wrap_next(tail_q);
				fill_q <= fill_q + FW'(1);
			end else if (cmd.pop) begin
				head_q <= wrap_next(head_q);
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			opcode_q <= opcode;
			id_q     <= bucket;
			mem_q    <= mem_in_use;
		end
		if (cmd.add_commit) begin
			fresh_q <= (cnt_rdata == '0);
		end
		if (cmd.pop) begin
			entry_q <= fifo_rdata;
		end
		if (cmd.res_load) begin
			ignored_q   <= (cmd.res == RES_IGNORED);
			fresh_out_q <= (cmd.res == RES_ADD) && fresh_q;
			ev_valid_q  <= (cmd.res == RES_EVICT);
			ev_bucket_q <= (cmd.res == RES_EVICT) ? entry_q : '0;
			case (cmd.res)
				RES_FULL:  err_q <= ERR_FULL;
				RES_EMPTY: err_q <= ERR_EMPTY;
				default:   err_q <= ERR_NONE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign ignored        = ignored_q;
	assign newly_tracked  = fresh_out_q;
	assign evicted_valid  = ev_valid_q;
	assign evicted_bucket = ev_bucket_q;
	assign error_code     = err_q;

endmodule

@@ hw/rtl/rfe_ctrl.sv @@
module rfe_ctrl import rfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISP,
		ST_ADD,
		ST_EV_ENT,
		ST_EV_CNT,
		ST_DONE
	} state_t;

	state_t    state_q;
	state_t    state_d;
	res_kind_t res_q;
	res_kind_t res_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '{default: '0, res: RES_NONE};
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = ST_DISP;
				end
			end
			ST_DISP: begin
				state_d = ST_DONE;
				if (!sts.is_evict) begin
					if (sts.pinned) begin
						res_d = RES_IGNORED;
					end else if (sts.full) begin
						res_d = RES_FULL;
					end else begin
						state_d = ST_ADD;
					end
				end else if (sts.below_limit) begin
					res_d = RES_NONE;
				end else if (sts.empty) begin
					res_d = RES_EMPTY;
				end else begin
					state_d = ST_EV_ENT;
				end
			end
			ST_ADD: begin
				cmd.add_commit = 1'b1;
				res_d          = RES_ADD;
				state_d        = ST_DONE;
			end
			ST_EV_ENT: begin
				cmd.pop          = 1'b1;
				cmd.cnt_rd_entry = 1'b1;
				state_d          = ST_EV_CNT;
			end
			ST_EV_CNT: begin
				if (sts.cnt_gt1) begin
					cmd.cnt_dec = 1'b1;
					if (sts.empty) begin
						res_d   = RES_EMPTY;
						state_d = ST_DONE;
					end else begin
						state_d = ST_EV_ENT;
					end
				end else begin
					cmd.cnt_clr = 1'b1;
					res_d       = RES_EVICT;
					state_d     = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.res = res_q;
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			res_q   <= RES_NONE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

@@ hw/rtl/refcounted_fifo_eviction_core.sv @@
// Channel  Handshake          Payload
// cfg      cfg_wr_en          cfg_index, cfg_data
// in       in_valid/in_stall  opcode, bucket, mem_in_use
// out      out_valid/out_stall ignored, newly_tracked, evicted_valid, evicted_bucket, error_code
//
// An add goes from accept through the dispatch, add and done states; a filtered add, a full
// queue, an empty queue or an evict below the limit goes from dispatch straight to done. An
// evict passes through the entry and count states for each popped entry, the read of the
// queue memory followed by the read of the count memory. The result goes valid in the same
// cycle that in_stall drops. After reset every entry of the count memory is cleared, one entry a cycle,
// with in_stall high. A result held by out_stall blocks the next item at its end.
module refcounted_fifo_eviction_core import rfe_pkg::*; #(
	parameter int NUM_BUCKETS = 4096,
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [ID_W-1:0]       bucket,
	input  logic [MEM_W-1:0]      mem_in_use,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  ignored,
	output logic                  newly_tracked,
	output logic                  evicted_valid,
	output logic [ID_W-1:0]       evicted_bucket,
	output logic [ERR_W-1:0]      error_code
);

	cmd_t cmd;
	sts_t sts;

	rfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rfe_datapath #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.bucket         (bucket),
		.mem_in_use     (mem_in_use),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ignored        (ignored),
		.newly_tracked  (newly_tracked),
		.evicted_valid  (evicted_valid),
		.evicted_bucket (evicted_bucket),
		.error_code     (error_code),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule
